[rtl/ult_pkg.sv]
// ult_pkg: shared types and constants of the unsorted list table
// used by unsorted_list_table_core, ult_checker and the testbench; no dependencies
package ult_pkg;

  localparam int unsigned Depth       = 16;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned CountBits   = 5;
  localparam int unsigned AddrBits    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    ModePut    = 3'd0,
    ModeFind   = 3'd1,
    ModeDelete = 3'd2,
    ModeClear  = 3'd3,
    ModeRewind = 3'd4,
    ModeNext   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2,
    StatusPastEnd  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StMove = 4'b0100,
    StNext = 4'b1000
  } state_e;

  typedef struct packed {
    logic [2:0]             mode;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } in_t;

  typedef struct packed {
    logic                   found;
    logic [KeyBits-1:0]     out_key;
    logic [PayloadBits-1:0] out_payload;
    logic [1:0]             status;
    logic [CountBits-1:0]   entry_count;
    logic                   is_full;
  } out_t;

  typedef struct packed {
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } entry_t;

endpackage

[rtl/ult_ram.sv]
// ult_ram: generic single write port, single read port ram with registered read
// no dependencies
module ult_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/unsorted_list_table_core.sv]
// unsorted_list_table_core: fixed-capacity unsorted key/payload table
// depends on ult_pkg and ult_ram
//
// usage
//   one input channel (in_valid_i/in_ready_o/in_data_i) carries a mode, a key
//   and a payload; one output channel (out_valid_o/out_ready_i/out_data_o)
//   returns exactly one result transaction per input transaction
//   entries live in a single ram with one read and one write port
// steps from input acceptance to result valid
//   put, clear, rewind, unused modes, refused operations: result registered
//   in the cycle after acceptance
//   next: slot read in StNext; find/delete: StScan compares slots in order to a
//   match (delete then StMove) or through every entry, skipped when empty
// throughput: one transaction in flight; a find or delete holds the input
//   channel while the linear scan reads one ram slot per cycle
// reset clears the entry count and the iterator; the ram needs no clearing
// a stalled receiver holds the result; the next input waits until it is taken
module unsorted_list_table_core
  import ult_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  state_e               state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [CountBits-1:0] iter_q, iter_d;
  logic [AddrBits-1:0]  idx_q, idx_d;
  logic [AddrBits-1:0]  hole_q, hole_d;
  in_t                  req_q, req_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  entry_t               ram_wdata;
  logic [AddrBits-1:0]  ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               rd_entry;

  logic                 in_fire;
  logic                 done;
  out_t                 res;
  in_t                  src;
  logic [CountBits-1:0] cnt_m1;

  ult_ram #(
    .Width($bits(entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry    = entry_t'(ram_rdata);
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt_m1      = count_q - CountBits'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iter_d      = iter_q;
    idx_d       = idx_q;
    hole_d      = hole_q;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AddrBits-1:0];
    ram_wdata   = '{key: in_data_i.key, payload: in_data_i.payload};
    ram_raddr   = '0;
    done        = 1'b0;
    src         = (state_q == StIdle) ? in_data_i : req_q;
    res         = '{found: 1'b0, out_key: src.key, out_payload: src.payload,
                    status: StatusOk, entry_count: '0, is_full: 1'b0};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          req_d = in_data_i;
          done  = 1'b1;
          case (in_data_i.mode)
            ModePut: begin
              if (count_q < CountBits'(Depth)) begin
                ram_we  = 1'b1;
                count_d = count_q + CountBits'(1);
              end else begin
                res.status = StatusFull;
              end
            end
            ModeFind, ModeDelete: begin
              if (count_q == '0) begin
                res.status = StatusNotFound;
              end else begin
                done    = 1'b0;
                idx_d   = '0;
                state_d = StScan;
              end
            end
            ModeClear: begin
              count_d = '0;
              iter_d  = '0;
            end
            ModeRewind: begin
              iter_d = '0;
            end
            ModeNext: begin
              if (iter_q < count_q) begin
                done      = 1'b0;
                ram_raddr = iter_q[AddrBits-1:0];
                state_d   = StNext;
              end else begin
                res.status = StatusPastEnd;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (rd_entry.key == req_q.key) begin
          res.found       = 1'b1;
          res.out_key     = rd_entry.key;
          res.out_payload = rd_entry.payload;
          if (req_q.mode == ModeDelete) begin
            hole_d    = idx_q;
            out_d     = res;
            ram_raddr = cnt_m1[AddrBits-1:0];
            state_d   = StMove;
          end else begin
            done = 1'b1;
          end
        end else if (idx_q == cnt_m1[AddrBits-1:0]) begin
          res.status = StatusNotFound;
          done       = 1'b1;
        end else begin
          idx_d     = idx_q + AddrBits'(1);
          ram_raddr = idx_q + AddrBits'(1);
        end
      end
      StMove: begin
        ram_we    = 1'b1;
        ram_waddr = hole_q;
        ram_wdata = rd_entry;
        count_d   = cnt_m1;
        res       = out_q;
        done      = 1'b1;
      end
      StNext: begin
        res.out_key     = rd_entry.key;
        res.out_payload = rd_entry.payload;
        iter_d          = iter_q + CountBits'(1);
        done            = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (done) begin
      out_d             = res;
      out_d.entry_count = count_d;
      out_d.is_full     = (count_d == CountBits'(Depth));
      out_valid_d       = 1'b1;
      state_d           = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    hole_q <= hole_d;
    req_q  <= req_d;
    out_q  <= out_d;
  end

endmodule

[rtl/ult_checker.sv]
// ult_checker: port-level assertions for unsorted_list_table_core, bound to it below
// depends on ult_pkg
module ult_checker
  import ult_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= CountBits'(Depth))
    else $error("entry count above capacity");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_full == (out_data_o.entry_count == CountBits'(Depth)))
    else $error("full flag disagrees with count");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == StatusOk)
    else $error("match reported with error status");

  // a put refused as full only when the count already sits at capacity
  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusFull |-> out_data_o.is_full)
    else $error("put refused below capacity");

endmodule

bind unsorted_list_table_core ult_checker u_ult_checker (.*);

[test/ult_checker.sv]
`timescale 1ns / 1ps
// ult_tb_checker: watches both channels of unsorted_list_table_core, predicts each result
// from its own copy of the table and compares it field by field; depends on ult_pkg
module ult_tb_checker
  import ult_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o
);

  logic [KeyBits-1:0]     key_mem     [Depth];
  logic [PayloadBits-1:0] payload_mem [Depth];
  int unsigned            table_count;
  int unsigned            iter_slot;
  int                     error_count = 0;
  out_t                   pending_results [$];

  assign errors_o = error_count;

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function automatic out_t table_op_result(in_t op);
    out_t        res;
    int unsigned slot;
    res.found       = 1'b0;
    res.out_key     = op.key;
    res.out_payload = op.payload;
    res.status      = StatusOk;
    case (op.mode)
      ModePut: begin
        if (table_count >= Depth) begin
          res.status = StatusFull;
        end else begin
          key_mem[table_count]     = op.key;
          payload_mem[table_count] = op.payload;
          table_count++;
        end
      end
      ModeFind, ModeDelete: begin
        slot = table_count;
        for (int unsigned i = 0; i < table_count; i++) begin
          if (slot == table_count && key_mem[i] == op.key) slot = i;
        end
        if (slot < table_count) begin
          res.found       = 1'b1;
          res.out_key     = key_mem[slot];
          res.out_payload = payload_mem[slot];
          if (op.mode == ModeDelete) begin
            key_mem[slot]     = key_mem[table_count - 1];
            payload_mem[slot] = payload_mem[table_count - 1];
            table_count--;
          end
        end else begin
          res.status = StatusNotFound;
        end
      end
      ModeClear: begin
        table_count = 0;
        iter_slot   = 0;
      end
      ModeRewind: begin
        iter_slot = 0;
      end
      ModeNext: begin
        if (iter_slot < table_count) begin
          res.out_key     = key_mem[iter_slot];
          res.out_payload = payload_mem[iter_slot];
          iter_slot++;
        end else begin
          res.status = StatusPastEnd;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = table_count[CountBits-1:0];
    res.is_full     = (table_count == Depth);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      table_count = 0;
      iter_slot   = 0;
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, got %h", $time, out_data_i);
        end else begin
          want = pending_results.pop_front();
          check_field("found", 64'(want.found), 64'(out_data_i.found));
          check_field("out_key", 64'(want.out_key), 64'(out_data_i.out_key));
          check_field("out_payload", 64'(want.out_payload), 64'(out_data_i.out_payload));
          check_field("status", 64'(want.status), 64'(out_data_i.status));
          check_field("entry_count", 64'(want.entry_count), 64'(out_data_i.entry_count));
          check_field("is_full", 64'(want.is_full), 64'(out_data_i.is_full));
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(table_op_result(in_data_i));
    end
    pending_o = pending_results.size();
  end

endmodule

[test/unsorted_list_table_core_test.sv]
`timescale 1ns / 1ps
// unsorted_list_table_core_test: drives table operations with random idling and a long
// receiver hold-off, and gives the verdict; depends on ult_pkg, ult_tb_checker and the core
module unsorted_list_table_core_test
  import ult_pkg::*;
();

  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int RandomItems   = 1100;
  localparam int IdleLimit     = 2000;
  localparam int DrainCycles   = Depth + 6;
  localparam int HoldOffCycles = 150;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   error_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   sent_items  = 0;
  bit   sender_idles;
  bit   hold_off_req;
  logic [KeyBits-1:0] key_pool [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  unsorted_list_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ult_tb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (error_count),
    .pending_o   (pending_count)
  );

  task automatic send_op(input logic [2:0] mode, input logic [KeyBits-1:0] key,
                         input logic [PayloadBits-1:0] payload);
    int gap;
    if (sent_items % 40 == 0) sender_idles = ($urandom_range(2) != 0);
    gap = sender_idles ? $urandom_range(12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, key: key, payload: payload};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_items++;
  endtask

  function automatic logic [KeyBits-1:0] pick_key();
    return ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom();
  endfunction

  initial begin
    int   bias;
    int   put_pct;
    int   del_pct;
    int   roll;
    logic [2:0] mode;
    in_valid     <= 1'b0;
    in_data      <= '0;
    rst_ni       <= 1'b0;
    hold_off_req = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[7] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, duplicates, delete with move, iterator past end
    send_op(ModeNext, '1, '1);
    send_op(ModeFind, '0, '0);
    send_op(ModeDelete, '1, '0);
    send_op(ModePut, '0, '0);
    send_op(ModePut, '1, '1);
    send_op(ModePut, '0, 32'h5a5a_a5a5);
    send_op(ModeFind, '0, '1);
    send_op(ModeFind, 32'h1234_5678, '0);
    send_op(ModeNext, '0, '0);
    send_op(ModeDelete, '0, '1);
    send_op(ModeNext, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    send_op(ModeNext, 32'hf0f0_f0f0, 32'h0f0f_0f0f);
    send_op(ModeRewind, '0, '0);
    send_op(ModeNext, '0, '0);
    send_op(ModeSpare6, '1, '1);
    send_op(ModeSpare7, 32'hdead_beef, 32'hcafe_f00d);
    send_op(ModeClear, '1, '1);
    send_op(ModeNext, '1, '0);
    // fill to capacity, then one refused put
    for (int i = 0; i <= Depth; i++) send_op(ModePut, key_pool[i % 8], $urandom());
    send_op(ModeFind, key_pool[3], '0);
    send_op(ModeDelete, key_pool[7], '0);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) bias = $urandom_range(2);
      if (n == 400) hold_off_req = 1'b1;
      put_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 30;
      del_pct = (bias == 0) ? 10 : (bias == 1) ? 40 : 20;
      roll    = $urandom_range(99);
      if (roll < put_pct) begin
        mode = ModePut;
      end else if (roll < put_pct + 20) begin
        mode = ModeFind;
      end else if (roll < put_pct + 20 + del_pct) begin
        mode = ModeDelete;
      end else begin
        roll = $urandom_range(99);
        if (roll < 50) mode = ModeNext;
        else if (roll < 70) mode = ModeRewind;
        else if (roll < 80) mode = ModeClear;
        else if (roll < 90) mode = ModeSpare6;
        else mode = ModeSpare7;
      end
      send_op(mode, pick_key(), $urandom());
    end
    in_valid <= 1'b0;

    do @(negedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    int taken;
    bit rx_idles;
    out_ready <= 1'b0;
    taken = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_idles = ($urandom_range(2) != 0);
      stall = rx_idles ? $urandom_range(12) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HoldOffCycles;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

[files.f]
rtl/ult_pkg.sv
rtl/ult_ram.sv
rtl/unsorted_list_table_core.sv
rtl/ult_checker.sv
test/ult_checker.sv
test/unsorted_list_table_core_test.sv
